/* design/tile_cache_lru_directory_macros.svh */
// assertion macros for the tile cache directory
`ifndef TILE_CACHE_LRU_DIRECTORY_MACROS_SVH
`define TILE_CACHE_LRU_DIRECTORY_MACROS_SVH
`ifndef SYNTHESIS
`define TCD_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("tcd assertion failed");
`define TCD_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("tcd assertion failed");
`else
`define TCD_ASSERT_IMP(label, clk, rst_n, a, c)
`define TCD_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

/* design/tcd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package tcd_pkg;
    localparam int OpW = 3;
    localparam int ZoomW = 5;
    localparam int CoordW = 24;
    localparam int SlotW = 6;
    localparam int AgeW = 32;
    localparam int KeyW = ZoomW + 2 * CoordW;

    typedef enum logic [OpW-1:0] {
        OP_LOOKUP   = 3'd0,
        OP_ABSENT   = 3'd1,
        OP_ALLOCATE = 3'd2,
        OP_COMMIT   = 3'd3,
        OP_FLUSH    = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_SLOT,
        ST_SCAN_ABSENT,
        ST_ALLOC,
        ST_FLUSH,
        ST_DONE,
        ST_INIT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // latch the command
        logic clr_idx;    // restart scan index
        logic step;       // advance scan index
        logic slot_scan;  // compare slot at index
        logic abs_scan;   // compare absent entry at index
        logic alloc_scan; // lru compare at index
        logic hit_write;  // stamp the hit slot
        logic alloc_write;// invalidate and stamp chosen slot
        logic abs_write;  // write absent ring
        logic commit;     // write slot key
        logic flush_step; // clear one entry per index
        logic flush_end;  // clear valid bits and reset pointer
        logic respond;    // drive result strobe
    } tcd_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic slot_last;
        logic abs_last;
        logic found;      // match seen at this index
        logic invalid;    // invalid slot seen at this index
    } tcd_stat_t;
endpackage
`default_nettype wire

/* design/tile_cache_lru_directory.sv */
`timescale 1ns / 1ps
`default_nettype none
// channel   | signals                                          | direction
// command   | start/busy(out), opcode, tile_zoom/col/row, slot_index | in
// result    | strobe, hit, known_absent, slot                   | out
//
// one beat in, one beat out; lookup time is set by the slot and absent memories,
// scanned one entry a cycle; allocate and flush walk the slot entries
// reset clears valid bits, age counter, ring cursor and controller, then busy
// stays high while the age store is cleared
// the result beat is shown for one cycle; the receiver cannot stall
module tile_cache_lru_directory #(
    parameter int CACHE_ENTRIES = 48,
    parameter int ABSENT_ENTRIES = 128
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [tcd_pkg::OpW-1:0]     opcode,
    input  wire logic [tcd_pkg::ZoomW-1:0]   tile_zoom,
    input  wire logic [tcd_pkg::CoordW-1:0]  tile_col,
    input  wire logic [tcd_pkg::CoordW-1:0]  tile_row,
    input  wire logic [tcd_pkg::SlotW-1:0]   slot_index,
    output logic                             strobe,
    output logic                             hit,
    output logic                             known_absent,
    output logic [tcd_pkg::SlotW-1:0]        slot
);
    tcd_pkg::tcd_cmd_t  cmd;
    tcd_pkg::tcd_stat_t stat;
    logic strobe_reg;

    // controller sequences the scans
    tcd_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .opcode(opcode),
        .busy(busy), .cmd(cmd), .stat(stat)
    );

    // datapath holds the stores and comparators
    tcd_datapath #(
        .CACHE_ENTRIES(CACHE_ENTRIES), .ABSENT_ENTRIES(ABSENT_ENTRIES)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .tile_zoom(tile_zoom), .tile_col(tile_col), .tile_row(tile_row),
        .slot_index(slot_index), .hit(hit), .known_absent(known_absent),
        .slot(slot)
    );

    // result beat is registered from the respond command, in the cycle after it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            strobe_reg <= 1'b0;
        else
            strobe_reg <= cmd.respond;
    end
    assign strobe = strobe_reg;
endmodule
`default_nettype wire

/* design/tcd_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "tile_cache_lru_directory_macros.svh"
module tcd_datapath #(
    parameter int CACHE_ENTRIES = 48,
    parameter int ABSENT_ENTRIES = 128
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire tcd_pkg::tcd_cmd_t           cmd,
    output tcd_pkg::tcd_stat_t               stat,
    input  wire logic [tcd_pkg::ZoomW-1:0]   tile_zoom,
    input  wire logic [tcd_pkg::CoordW-1:0]  tile_col,
    input  wire logic [tcd_pkg::CoordW-1:0]  tile_row,
    input  wire logic [tcd_pkg::SlotW-1:0]   slot_index,
    output logic                             hit,
    output logic                             known_absent,
    output logic [tcd_pkg::SlotW-1:0]        slot
);
    localparam int CW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int AW = (ABSENT_ENTRIES > 1) ? $clog2(ABSENT_ENTRIES) : 1;
    localparam int IW = ((CW > AW) ? CW : AW) + 1;

    // key and age stores are memories, one read and one write port each
    logic [tcd_pkg::KeyW-1:0] slot_key_mem [CACHE_ENTRIES];
    logic [tcd_pkg::AgeW-1:0] slot_age_mem [CACHE_ENTRIES];
    logic [tcd_pkg::KeyW-1:0] abs_key_mem  [ABSENT_ENTRIES];
    logic [CACHE_ENTRIES-1:0]  slot_valid_reg;
    logic [ABSENT_ENTRIES-1:0] abs_valid_reg;

    logic [tcd_pkg::KeyW-1:0] key_reg;
    logic [tcd_pkg::SlotW-1:0] idx_in_reg;
    logic [IW-1:0] idx_reg;
    logic [tcd_pkg::KeyW-1:0] slot_rd_reg;
    logic [tcd_pkg::KeyW-1:0] abs_rd_reg;
    logic [tcd_pkg::AgeW-1:0] age_rd_reg;
    logic [IW-1:0] rd_idx_reg;     // index the read data belongs to
    logic [AW-1:0] abs_ptr_reg;
    logic [tcd_pkg::AgeW-1:0] age_ctr_reg;
    logic [CW-1:0] best_reg;
    logic [tcd_pkg::AgeW-1:0] best_age_reg;
    logic hit_reg, abs_reg;
    logic [tcd_pkg::SlotW-1:0] res_slot_reg;
    logic strobe_reg;
    logic [CW-1:0] rd_c;
    logic [AW-1:0] rd_a;
    logic [tcd_pkg::AgeW-1:0] age_next;
    logic [tcd_pkg::AgeW-1:0] cur_age;
    logic take_c;
    logic [CW-1:0] victim_c;

    assign rd_c = rd_idx_reg[CW-1:0];
    assign rd_a = rd_idx_reg[AW-1:0];
    assign age_next = age_ctr_reg + 1'b1;
    // age read back for the compared slot
    assign cur_age = age_rd_reg;

    // victim is the running choice or the slot compared this cycle
    tcd_alloc_fix #(
        .CW(CW)
    ) u_victim (
        .scan(cmd.alloc_scan), .invalid(stat.invalid), .rd_idx(rd_c),
        .rd_age(cur_age), .best(best_reg), .best_age(best_age_reg),
        .take(take_c), .victim(victim_c)
    );

    always_ff @(posedge clk)
    begin
        slot_rd_reg <= slot_key_mem[idx_reg[CW-1:0]];
        age_rd_reg  <= slot_age_mem[idx_reg[CW-1:0]];
        abs_rd_reg  <= abs_key_mem[idx_reg[AW-1:0]];
        if (cmd.load)
        begin
            key_reg <= {tile_zoom, tile_col, tile_row};
            idx_in_reg <= slot_index;
        end
        if (cmd.commit && idx_in_reg < tcd_pkg::SlotW'(CACHE_ENTRIES))
            slot_key_mem[idx_in_reg[CW-1:0]] <= key_reg;
        if (cmd.abs_write)
            abs_key_mem[abs_ptr_reg] <= key_reg;
        if (cmd.hit_write)
            slot_age_mem[rd_c] <= age_next;
        else if (cmd.alloc_write)
            slot_age_mem[victim_c] <= age_next;
        else if (cmd.flush_step)
            slot_age_mem[idx_reg[CW-1:0]] <= '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
            abs_valid_reg <= '0;
            abs_ptr_reg <= '0;
            age_ctr_reg <= '0;
            idx_reg <= '0;
            rd_idx_reg <= '0;
            strobe_reg <= 1'b0;
            hit_reg <= 1'b0;
            abs_reg <= 1'b0;
            best_reg <= '0;
            best_age_reg <= '0;
            res_slot_reg <= '0;
        end
        else
        begin
            strobe_reg <= cmd.respond;
            rd_idx_reg <= idx_reg;
            if (cmd.clr_idx)
                idx_reg <= '0;
            else if (cmd.step)
                idx_reg <= idx_reg + 1'b1;
            if (cmd.load)
            begin
                hit_reg <= 1'b0;
                abs_reg <= 1'b0;
                res_slot_reg <= '0;
                best_reg <= '0;
                best_age_reg <= '0;
            end
            if (cmd.slot_scan && stat.found)
            begin
                hit_reg <= 1'b1;
                res_slot_reg <= tcd_pkg::SlotW'(rd_c);
            end
            if (cmd.abs_scan && stat.found)
                abs_reg <= 1'b1;
            if (take_c)
            begin
                best_reg <= rd_c;
                best_age_reg <= cur_age;
            end
            if (cmd.hit_write)
                age_ctr_reg <= age_next;
            if (cmd.alloc_write)
            begin
                age_ctr_reg <= age_next;
                slot_valid_reg[victim_c] <= 1'b0;
                res_slot_reg <= tcd_pkg::SlotW'(victim_c);
            end
            if (cmd.commit && idx_in_reg < tcd_pkg::SlotW'(CACHE_ENTRIES))
                slot_valid_reg[idx_in_reg[CW-1:0]] <= 1'b1;
            if (cmd.abs_write)
            begin
                abs_valid_reg[abs_ptr_reg] <= 1'b1;
                abs_ptr_reg <= (abs_ptr_reg == AW'(ABSENT_ENTRIES - 1)) ? '0
                               : abs_ptr_reg + 1'b1;
            end
            if (cmd.flush_end)
            begin
                slot_valid_reg <= '0;
                abs_valid_reg <= '0;
                abs_ptr_reg <= '0;
            end
        end
    end

    always_comb
    begin
        stat.slot_last = (idx_reg == IW'(CACHE_ENTRIES - 1));
        stat.abs_last = (idx_reg == IW'(ABSENT_ENTRIES - 1));
        stat.invalid = !slot_valid_reg[rd_c];
        if (cmd.abs_scan)
            stat.found = abs_valid_reg[rd_a] && abs_rd_reg == key_reg;
        else
            stat.found = slot_valid_reg[rd_c] && slot_rd_reg == key_reg;
    end

    assign hit = strobe_reg & hit_reg;
    assign known_absent = strobe_reg & abs_reg & ~hit_reg;
    assign slot = strobe_reg ? res_slot_reg : '0;

    `TCD_ASSERT_IMP(a_abs_excl, clk, rst_n, strobe_reg && hit_reg, !known_absent)
    `TCD_ASSERT_NXT(a_age_step, clk, rst_n, cmd.hit_write, age_ctr_reg == $past(age_ctr_reg) + 1'b1)
    `TCD_ASSERT_NXT(a_alloc_inv, clk, rst_n, cmd.alloc_write, !slot_valid_reg[$past(victim_c)])
endmodule
`default_nettype wire

/* design/tcd_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "tile_cache_lru_directory_macros.svh"
module tcd_ctrl (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic [tcd_pkg::OpW-1:0] opcode,
    output logic                         busy,
    output tcd_pkg::tcd_cmd_t            cmd,
    input  wire tcd_pkg::tcd_stat_t      stat
);
    tcd_pkg::state_t state_reg, state_next;
    logic [tcd_pkg::OpW-1:0] op_reg;
    logic last_reg, last_next;   // last read is in flight
    logic stop_reg, stop_next;   // compare is armed: read data is valid

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tcd_pkg::ST_INIT;
            op_reg <= '0;
            last_reg <= 1'b0;
            stop_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            last_reg <= last_next;
            stop_reg <= stop_next;
            if (start && !busy)
                op_reg <= opcode;
        end
    end

    // scans: index runs one ahead of the compared read data
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        last_next = last_reg;
        stop_next = stop_reg;
        busy = (state_reg != tcd_pkg::ST_IDLE);
        unique case (state_reg)
            tcd_pkg::ST_INIT:
            begin
                // clear the age store once after reset
                cmd.step = 1'b1;
                cmd.flush_step = 1'b1;
                if (stat.slot_last)
                    state_next = tcd_pkg::ST_IDLE;
            end
            tcd_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    cmd.clr_idx = 1'b1;
                    last_next = 1'b0;
                    stop_next = 1'b0;
                    priority case (opcode)
                        tcd_pkg::OP_LOOKUP:   state_next = tcd_pkg::ST_SCAN_SLOT;
                        tcd_pkg::OP_ALLOCATE: state_next = tcd_pkg::ST_ALLOC;
                        tcd_pkg::OP_FLUSH:    state_next = tcd_pkg::ST_FLUSH;
                        default:              state_next = tcd_pkg::ST_DONE;
                    endcase
                end
            end
            tcd_pkg::ST_SCAN_SLOT:
            begin
                cmd.step = !last_reg;
                cmd.slot_scan = stop_reg;
                if (stop_reg && stat.found)
                begin
                    cmd.hit_write = 1'b1;
                    state_next = tcd_pkg::ST_DONE;
                end
                else if (last_reg && stop_reg)
                begin
                    cmd.clr_idx = 1'b1;
                    last_next = 1'b0;
                    stop_next = 1'b0;
                    state_next = tcd_pkg::ST_SCAN_ABSENT;
                end
                else
                begin
                    stop_next = 1'b1;
                    if (stat.slot_last)
                        last_next = 1'b1;
                end
            end
            tcd_pkg::ST_SCAN_ABSENT:
            begin
                cmd.step = !last_reg;
                cmd.abs_scan = stop_reg;
                if ((stop_reg && stat.found) || (last_reg && stop_reg))
                    state_next = tcd_pkg::ST_DONE;
                else
                begin
                    stop_next = 1'b1;
                    if (stat.abs_last)
                        last_next = 1'b1;
                end
            end
            tcd_pkg::ST_ALLOC:
            begin
                cmd.step = !last_reg;
                cmd.alloc_scan = stop_reg;
                if (stop_reg && (stat.invalid || last_reg))
                begin
                    // first invalid slot wins outright, else oldest after the last compare
                    cmd.alloc_write = 1'b1;
                    state_next = tcd_pkg::ST_DONE;
                end
                else
                begin
                    stop_next = 1'b1;
                    if (stat.slot_last)
                        last_next = 1'b1;
                end
            end
            tcd_pkg::ST_FLUSH:
            begin
                cmd.step = 1'b1;
                cmd.flush_step = 1'b1;
                if (stat.slot_last)
                begin
                    cmd.flush_end = 1'b1;
                    state_next = tcd_pkg::ST_DONE;
                end
            end
            tcd_pkg::ST_DONE:
            begin
                if (op_reg == tcd_pkg::OP_COMMIT)
                    cmd.commit = 1'b1;
                if (op_reg == tcd_pkg::OP_ABSENT)
                    cmd.abs_write = 1'b1;
                cmd.respond = 1'b1;
                state_next = tcd_pkg::ST_IDLE;
            end
            default: state_next = tcd_pkg::ST_IDLE;
        endcase
    end

    `TCD_ASSERT_NXT(a_start_leaves_idle, clk, rst_n, start && !busy, busy)
    `TCD_ASSERT_NXT(a_done_to_idle, clk, rst_n, state_reg == tcd_pkg::ST_DONE, !busy)
    `TCD_ASSERT_IMP(a_one_write, clk, rst_n, cmd.hit_write, !cmd.alloc_write && !cmd.flush_step)
endmodule
`default_nettype wire

/* design/tcd_alloc_fix.sv */
`timescale 1ns / 1ps
`default_nettype none
// picks the allocate victim at the compared slot
module tcd_alloc_fix #(
    parameter int CW = 6
) (
    input  wire logic                      scan,
    input  wire logic                      invalid,
    input  wire logic [CW-1:0]             rd_idx,
    input  wire logic [tcd_pkg::AgeW-1:0]  rd_age,
    input  wire logic [CW-1:0]             best,
    input  wire logic [tcd_pkg::AgeW-1:0]  best_age,
    output logic                           take,
    output logic [CW-1:0]                  victim
);
    // an invalid slot, the first slot or a strictly older one takes over
    // ties keep the lower index
    assign take = scan && (invalid || rd_idx == '0 || rd_age < best_age);
    assign victim = take ? rd_idx : best;
endmodule
`default_nettype wire
